>>> sv/cls_pkg.sv
package cls_pkg;

    localparam int NEST_BITS_DEFAULT   = 8;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] CHAR_SEMI      = 8'h3B;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE    = 8'h7D;

    typedef enum logic [1:0] {
        KIND_WORD = 2'd0,
        KIND_ARG  = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_SKIP_CMD = 2'd0,
        PH_WORD     = 2'd1,
        PH_SKIP_ARG = 2'd2,
        PH_ARG      = 2'd3
    } phase_t;

    // up to two results for one input byte: an optional item, then an optional line-end mark
    typedef struct packed {
        logic       has_item;
        kind_t      kind;
        logic [7:0] text;
        logic       has_end;
    } entry_t;

    typedef struct packed {
        logic   emit;
        logic   end_cmd;
        logic   esc_set;
        logic   esc_clr;
        logic   wide_set;
        logic   wide_clr;
        logic   quote_tgl;
        logic   brace_inc;
        logic   brace_dec;
        logic   phase_chg;
        phase_t phase_to;
        kind_t  kind;
    } action_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
    endfunction

endpackage

>>> sv/cls_front.sv
module cls_front #(
    parameter int NEST_BITS = cls_pkg::NEST_BITS_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [7:0]      s_axis_tdata,
    input  logic            s_axis_tlast,
    input  logic            cfg_valid,
    input  logic            cfg_data,
    input  logic            q_ready,
    output logic            q_push,
    output cls_pkg::entry_t q_entry
);
    import cls_pkg::*;

    localparam logic signed [NEST_BITS-1:0] DEPTH_MAX = {1'b0, {(NEST_BITS-1){1'b1}}};
    localparam logic signed [NEST_BITS-1:0] DEPTH_MIN = {1'b1, {(NEST_BITS-1){1'b0}}};
    localparam logic signed [NEST_BITS-1:0] DEPTH_ONE = NEST_BITS'(1);

    phase_t                      phase_reg, phase_next;
    logic                        line_start_reg, line_start_next;
    logic                        quoted_reg, quoted_next;
    logic                        escape_reg, escape_next;
    logic                        wide_reg, wide_next;
    logic signed [NEST_BITS-1:0] depth_reg, depth_next;
    logic                        dbe_reg;

    action_t    act;
    logic       accept;
    logic       do_word;
    logic       do_arg;
    logic [7:0] b;

    assign b             = s_axis_tdata;
    assign s_axis_tready = q_ready;
    assign accept        = s_axis_tvalid && q_ready;

    // classify the byte against the current state
    always_comb begin
        act      = '0;
        act.kind = KIND_WORD;
        act.phase_to = phase_reg;
        do_word  = 1'b0;
        do_arg   = 1'b0;
        unique case (phase_reg)
            PH_SKIP_CMD: begin
                if (is_ws(b)) begin
                    act = act;
                end else if (b == CHAR_SEMI) begin
                    act.end_cmd = !line_start_reg;
                end else begin
                    act.phase_chg = 1'b1;
                    act.phase_to  = PH_WORD;
                    do_word       = 1'b1;
                end
            end
            PH_WORD: do_word = 1'b1;
            PH_SKIP_ARG: begin
                if (!is_ws(b)) begin
                    act.phase_chg = 1'b1;
                    act.phase_to  = PH_ARG;
                    do_arg        = 1'b1;
                end
            end
            PH_ARG: do_arg = 1'b1;
        endcase

        if (do_word) begin
            act.kind = KIND_WORD;
            priority if (escape_reg) begin
                act.esc_clr = 1'b1;
                act.emit    = 1'b1;
            end else if (wide_reg) begin
                act.wide_clr = 1'b1;
                act.emit     = 1'b1;
            end else if (b == CHAR_BACKSLASH) begin
                act.esc_set = 1'b1;
            end else if (dbe_reg && b[7]) begin
                act.wide_set = 1'b1;
                act.emit     = 1'b1;
            end else if (b == CHAR_QUOTE) begin
                act.quote_tgl = 1'b1;
            end else if (b == CHAR_SEMI) begin
                if (quoted_reg) begin
                    act.emit = 1'b1;
                end else begin
                    act.end_cmd = 1'b1;
                end
            end else if (!quoted_reg && b == CHAR_SPACE) begin
                act.phase_chg = 1'b1;
                act.phase_to  = PH_SKIP_ARG;
            end else begin
                act.emit = 1'b1;
            end
        end

        if (do_arg) begin
            act.kind = KIND_ARG;
            priority if (escape_reg) begin
                act.esc_clr = 1'b1;
                act.emit    = 1'b1;
            end else if (wide_reg) begin
                act.wide_clr = 1'b1;
                act.emit     = 1'b1;
            end else if (b == CHAR_BACKSLASH) begin
                act.esc_set = 1'b1;
                act.emit    = 1'b1;
            end else if (dbe_reg && b[7]) begin
                act.wide_set = 1'b1;
                act.emit     = 1'b1;
            end else if (b == CHAR_SEMI && depth_reg < DEPTH_ONE) begin
                act.end_cmd = 1'b1;
            end else if (b == CHAR_LBRACE) begin
                act.brace_inc = depth_reg < DEPTH_MAX;
                act.emit      = 1'b1;
            end else if (b == CHAR_RBRACE) begin
                act.brace_dec = depth_reg > DEPTH_MIN;
                act.emit      = 1'b1;
            end else begin
                act.emit = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        phase_next      = act.phase_chg ? act.phase_to : phase_reg;
        quoted_next     = quoted_reg ^ act.quote_tgl;
        escape_next     = (escape_reg && !act.esc_clr) || act.esc_set;
        wide_next       = (wide_reg && !act.wide_clr) || act.wide_set;
        depth_next      = depth_reg;
        line_start_next = 1'b0;
        if (act.brace_inc) begin
            depth_next = depth_reg + DEPTH_ONE;
        end else if (act.brace_dec) begin
            depth_next = depth_reg - DEPTH_ONE;
        end
        if (act.end_cmd || s_axis_tlast) begin
            phase_next  = PH_SKIP_CMD;
            quoted_next = 1'b0;
            escape_next = 1'b0;
            wide_next   = 1'b0;
            depth_next  = '0;
        end
        if (s_axis_tlast) begin
            line_start_next = 1'b1;
        end
    end

    // queue entry
    always_comb begin
        q_entry.has_item = act.emit || act.end_cmd;
        q_entry.kind     = act.end_cmd ? KIND_END : act.kind;
        q_entry.text     = act.end_cmd ? 8'h00 : b;
        q_entry.has_end  = s_axis_tlast;
        q_push           = accept && (act.emit || act.end_cmd || s_axis_tlast);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SKIP_CMD;
            line_start_reg <= 1'b1;
            quoted_reg     <= 1'b0;
            escape_reg     <= 1'b0;
            wide_reg       <= 1'b0;
            depth_reg      <= '0;
            dbe_reg        <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg      <= phase_next;
                line_start_reg <= line_start_next;
                quoted_reg     <= quoted_next;
                escape_reg     <= escape_next;
                wide_reg       <= wide_next;
                depth_reg      <= depth_next;
            end
            if (cfg_valid) begin
                dbe_reg <= cfg_data;
            end
        end
    end

endmodule

>>> sv/cls_queue.sv
module cls_queue #(
    parameter int DEPTH = cls_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  cls_pkg::entry_t push_entry,
    output logic            push_ready,
    input  logic            pop,
    output logic            head_valid,
    output cls_pkg::entry_t head_entry
);
    import cls_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/cls_back.sv
module cls_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  cls_pkg::entry_t head_entry,
    output logic            pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata,  // text_byte
    output logic [1:0]      m_axis_tuser,  // item_kind
    output logic            m_axis_tlast   // run_last
);
    import cls_pkg::*;

    logic       first_done_reg, first_done_next;
    logic       valid_reg, valid_next;
    kind_t      kind_reg, kind_next;
    logic [7:0] text_reg, text_next;
    logic       last_reg, last_next;
    logic       load;
    logic       take_item;
    logic       entry_done;

    assign load       = !valid_reg || m_axis_tready;
    assign take_item  = head_entry.has_item && !first_done_reg;
    assign entry_done = !take_item || !head_entry.has_end;
    assign pop        = load && head_valid && entry_done;

    always_comb begin
        first_done_next = first_done_reg;
        valid_next      = valid_reg;
        kind_next       = kind_reg;
        text_next       = text_reg;
        last_next       = last_reg;
        if (load) begin
            valid_next = head_valid;
            if (head_valid) begin
                kind_next       = take_item ? head_entry.kind : KIND_END;
                text_next       = take_item ? head_entry.text : 8'h00;
                last_next       = entry_done;
                first_done_next = !entry_done;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        text_reg <= text_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_done_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end else begin
            first_done_reg <= first_done_next;
            valid_reg      <= valid_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = text_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;

endmodule

>>> sv/command_line_splitter_core.sv
// Command line splitter. Takes one line byte per beat (tlast marks the last byte of the line)
// and emits tagged beats: command-word bytes, argument bytes and command-end marks, with tlast
// on the last beat caused by each input byte. An input byte is accepted every cycle while the
// queue between classifier and output stage has room; the output side delivers one beat per cycle
// while m_axis_tready is high. A byte that yields two results (a line end) fills two output beats,
// and the queue of QUEUE_DEPTH entries absorbs such bursts. Results pass through the queue and
// the output register. cfg_data sets double-byte mode; write it only while the block is idle.
module command_line_splitter_core #(
    parameter int NEST_BITS   = cls_pkg::NEST_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = cls_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // line_byte
    input  logic       s_axis_tlast,   // line_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // text_byte
    output logic [1:0] m_axis_tuser,   // item_kind
    output logic       m_axis_tlast,   // run_last
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data        // double_byte_enable
);
    import cls_pkg::*;

    logic   q_push;
    logic   q_ready;
    entry_t q_entry;
    logic   q_pop;
    logic   head_valid;
    entry_t head_entry;

    assign cfg_ready = 1'b1;

    cls_front #(
        .NEST_BITS(NEST_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .q_entry      (q_entry)
    );

    cls_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(q_entry),
        .push_ready(q_ready),
        .pop       (q_pop),
        .head_valid(head_valid),
        .head_entry(head_entry)
    );

    cls_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (q_pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import cls_pkg::*;

    localparam int NEST       = NEST_BITS_DEFAULT;
    localparam int TAIL       = 16;
    localparam int QUIET_MAX  = 2000;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } line_byte_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] text;
        logic       last;
    } beat_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic       cfg_data      = 1'b0;

    line_byte_t pending_bytes[$];
    beat_t      expected_beats[$];
    int         issued     = 0;
    int         errors     = 0;
    int         quiet      = 0;
    int         send_idle  = 0;
    int         recv_stall = 0;

    // splitter state as seen by the checker
    phase_t     cur_phase  = PH_SKIP_CMD;
    bit         line_start = 1'b1;
    bit         in_quote   = 1'b0;
    bit         esc_on     = 1'b0;
    bit         wide_on    = 1'b0;
    bit         dbl_mode   = 1'b0;
    int         brace_lvl  = 0;
    beat_t      step_beats[2];
    int         step_n;

    command_line_splitter_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // line_byte
        .s_axis_tlast  (s_axis_tlast),   // line_end
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // text_byte
        .m_axis_tuser  (m_axis_tuser),   // item_kind
        .m_axis_tlast  (m_axis_tlast),   // run_last
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)        // double_byte_enable
    );

    always #6 aclk = ~aclk;

    function automatic bit is_blank(logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic void emit_beat(kind_t k, logic [7:0] t);
        if (step_n < 2) begin
            step_beats[step_n].kind = k;
            step_beats[step_n].text = t;
            step_beats[step_n].last = 1'b0;
            step_n++;
        end
    endfunction

    function automatic void close_cmd();
        emit_beat(KIND_END, 8'h00);
        cur_phase = PH_SKIP_CMD;
        in_quote  = 1'b0;
        esc_on    = 1'b0;
        wide_on   = 1'b0;
        brace_lvl = 0;
    endfunction

    function automatic void word_char(logic [7:0] b);
        if (esc_on) begin
            esc_on = 1'b0;
            emit_beat(KIND_WORD, b);
        end else if (wide_on) begin
            wide_on = 1'b0;
            emit_beat(KIND_WORD, b);
        end else if (b == CHAR_BACKSLASH) begin
            esc_on = 1'b1;
        end else if (dbl_mode && b[7]) begin
            wide_on = 1'b1;
            emit_beat(KIND_WORD, b);
        end else if (b == CHAR_QUOTE) begin
            in_quote = !in_quote;
        end else if (b == CHAR_SEMI) begin
            if (in_quote)
                emit_beat(KIND_WORD, b);
            else
                close_cmd();
        end else if (!in_quote && b == CHAR_SPACE) begin
            cur_phase = PH_SKIP_ARG;
        end else begin
            emit_beat(KIND_WORD, b);
        end
    endfunction

    function automatic void arg_char(logic [7:0] b);
        int top;
        top = (1 << (NEST - 1)) - 1;
        if (esc_on) begin
            esc_on = 1'b0;
            emit_beat(KIND_ARG, b);
        end else if (wide_on) begin
            wide_on = 1'b0;
            emit_beat(KIND_ARG, b);
        end else if (b == CHAR_BACKSLASH) begin
            esc_on = 1'b1;
            emit_beat(KIND_ARG, b);
        end else if (dbl_mode && b[7]) begin
            wide_on = 1'b1;
            emit_beat(KIND_ARG, b);
        end else if (b == CHAR_SEMI && brace_lvl < 1) begin
            close_cmd();
        end else begin
            if (b == CHAR_LBRACE && brace_lvl < top)
                brace_lvl++;
            if (b == CHAR_RBRACE && brace_lvl > -top - 1)
                brace_lvl--;
            emit_beat(KIND_ARG, b);
        end
    endfunction

    function automatic void split_byte(logic [7:0] b, logic last);
        step_n = 0;
        case (cur_phase)
            PH_SKIP_CMD: begin
                if (!is_blank(b)) begin
                    if (b == CHAR_SEMI) begin
                        if (!line_start)
                            close_cmd();
                    end else begin
                        cur_phase = PH_WORD;
                        word_char(b);
                    end
                end
            end
            PH_WORD: word_char(b);
            PH_SKIP_ARG: begin
                if (!is_blank(b)) begin
                    cur_phase = PH_ARG;
                    arg_char(b);
                end
            end
            default: arg_char(b);
        endcase
        line_start = 1'b0;
        if (last) begin
            close_cmd();
            line_start = 1'b1;
        end
        for (int i = 0; i < step_n; i++) begin
            step_beats[i].last = (i == step_n - 1);
            expected_beats.push_back(step_beats[i]);
        end
    endfunction

    always @(posedge aclk) begin
        line_byte_t nxt;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                split_byte(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle) begin
                    nxt = pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.b;
                    s_axis_tlast  <= nxt.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        beat_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected beat: item_kind %0d text_byte %02h run_last %0d",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                want = expected_beats.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $error("item_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata !== want.text) begin
                    $error("text_byte: expected %02h, got %02h", want.text, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("run_last: expected %0d, got %0d", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_MAX) begin
            $display("[command_line_splitter_core] ERROR");
            $finish;
        end
    end

    task automatic push_byte(logic [7:0] b, logic last);
        line_byte_t it;
        it.b    = b;
        it.last = last;
        pending_bytes.push_back(it);
        issued++;
    endtask

    task automatic push_line(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(99);
        if (r < 30) return 8'(8'h61 + $urandom_range(25));
        if (r < 34) return CHAR_SPACE;
        if (r < 38) return 8'(CHAR_TAB + $urandom_range(4));
        if (r < 46) return CHAR_SEMI;
        if (r < 52) return CHAR_BACKSLASH;
        if (r < 58) return CHAR_QUOTE;
        if (r < 66) return CHAR_LBRACE;
        if (r < 74) return CHAR_RBRACE;
        if (r < 86) return 8'(8'h80 + $urandom_range(127));
        return 8'($urandom_range(255));
    endfunction

    task automatic add_random_line();
        logic [7:0] bytes_q[$];
        int         ncmd;
        int         n;
        if ($urandom_range(3) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) bytes_q.push_back(rand_char());
        end else begin
            ncmd = $urandom_range(1, 3);
            for (int c = 0; c < ncmd; c++) begin
                if ($urandom_range(2) == 0)
                    bytes_q.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
                n = $urandom_range(1, 5);
                repeat (n)
                    bytes_q.push_back($urandom_range(4) == 0 ? rand_char()
                                                             : 8'(8'h61 + $urandom_range(25)));
                bytes_q.push_back(CHAR_SPACE);
                n = $urandom_range(0, 6);
                repeat (n) bytes_q.push_back(rand_char());
                if (c < ncmd - 1)
                    bytes_q.push_back(CHAR_SEMI);
            end
        end
        foreach (bytes_q[i])
            push_byte(bytes_q[i], i == bytes_q.size() - 1);
    endtask

    task automatic add_random(int count);
        int target;
        target = issued + count;
        while (issued < target)
            add_random_line();
    endtask

    task automatic drain();
        while (pending_bytes.size() > 0 || s_axis_tvalid || expected_beats.size() > 0)
            @(posedge aclk);
        repeat (TAIL) @(posedge aclk);
    endtask

    task automatic write_mode(bit v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        dbl_mode = v;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle  = 12;
        recv_stall = 46;
        push_line(";;a\\;\" ;\" {;}\\;;");
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(CHAR_SPACE, 1'b0);
        push_byte(CHAR_RBRACE, 1'b0);
        push_byte(CHAR_BACKSLASH, 1'b1);
        push_line("\\");
        push_line(";");
        add_random(100);
        drain();

        write_mode(1'b1);
        push_byte(8'hA0, 1'b0);
        push_byte(CHAR_SEMI, 1'b0);
        push_byte(CHAR_SPACE, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(CHAR_SEMI, 1'b0);
        push_byte(CHAR_BACKSLASH, 1'b1);
        add_random(150);
        drain();

        send_idle  = 46;
        recv_stall = 12;
        write_mode(1'b0);
        push_byte("s", 1'b0);
        push_byte(CHAR_SPACE, 1'b0);
        repeat (130) push_byte(CHAR_LBRACE, 1'b0);
        push_byte(CHAR_SEMI, 1'b0);
        repeat (260) push_byte(CHAR_RBRACE, 1'b0);
        push_byte(CHAR_SEMI, 1'b1);
        add_random(120);
        drain();

        write_mode(1'b1);
        add_random(150);
        drain();

        send_idle  = 0;
        recv_stall = 0;
        write_mode(1'b0);
        add_random(80);
        drain();

        write_mode(1'b1);
        add_random(80);
        drain();

        if (errors == 0)
            $display("[command_line_splitter_core] OK");
        else
            $display("[command_line_splitter_core] ERROR");
        $finish;
    end

endmodule

>>> sim.f
sv/cls_pkg.sv
sv/cls_front.sv
sv/cls_queue.sv
sv/cls_back.sv
sv/command_line_splitter_core.sv
tb/tb.sv
